[hw/rtl/bbsm_pkg.sv]
// Shared types, register indexes and coordinate helpers for the button box stick mapper.
package bbsm_pkg;

   typedef enum logic [1:0] {
      REG_SOCD_MODE   = 2'd0,
      REG_BAN_PARASOL = 2'd1,
      REG_BAN_SIDE_B  = 2'd2
   } csr_index_type;

   localparam logic SOCD_CANCEL   = 1'b0;
   localparam logic SOCD_PRIORITY = 1'b1;

   localparam logic [7:0] TRIG_FULL  = 8'd140;
   localparam logic [7:0] TRIG_MID   = 8'd94;
   localparam logic [7:0] TRIG_LIGHT = 8'd49;
   localparam logic [7:0] TRIG_OFF   = 8'd0;

   localparam logic [7:0] COORD_CENTER = 8'd128;

   // One button snapshot as captured at the input register.
   typedef struct packed {
      logic [3:0] direction_buttons;
      logic [1:0] modifier_buttons;
      logic [3:0] shield_buttons;
      logic [3:0] c_buttons;
      logic [3:0] dpad_buttons;
      logic [5:0] face_buttons;
   } req_item_type;

   // One gamepad report.
   typedef struct packed {
      logic [7:0] stick_x;
      logic [7:0] stick_y;
      logic [7:0] c_stick_x;
      logic [7:0] c_stick_y;
      logic [3:0] dpad_out;
      logic [7:0] left_trigger;
      logic [7:0] right_trigger;
      logic [7:0] button_bits;
   } rsp_item_type;

   // Offset-binary coordinate from a signed table step; the sum wraps mod 256.
   function automatic logic [7:0] coord(input logic signed [7:0] k);
      coord = COORD_CENTER + k;
   endfunction

   function automatic logic [7:0] mirror(input logic [7:0] c);
      mirror = 8'd0 - c;
   endfunction

endpackage

[hw/rtl/button_box_stick_mapper_top.sv]
// Button box stick mapper: button snapshots in, gamepad reports out.
//
// Usage: each transfer on the req_ channel carries one snapshot of all
// controller buttons; each transfer on the rsp_ channel returns one gamepad
// report (main stick, C-stick, d-pad, trigger levels and button bits), in
// order, exactly one report per snapshot.
// The block has an input register and a result register. rsp_valid rises
// once a snapshot has moved from the input register into the result
// register, which waits while the receiver stalls; one snapshot is taken
// every cycle while req_stall is low. In second-input priority mode the
// opposite-direction state (last pressed and locked-out directions) is
// updated as a snapshot moves from the input register into the result
// register, so the result path is one pass of table lookup logic.
// When rsp_stall is high the report holds, the input register fills, and
// then req_stall rises until the receiver takes the report.
// Reset empties both registers, clears the direction state and returns the
// csr_ registers to second-input priority with both bans off. Registers are
// written through csr_write_en, csr_index and csr_wdata by the user only
// while idle, which the block does not enforce; an unused index is ignored.
module button_box_stick_mapper_top
   import bbsm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [3:0] req_direction_buttons,
   input  logic [1:0] req_modifier_buttons,
   input  logic [3:0] req_shield_buttons,
   input  logic [3:0] req_c_buttons,
   input  logic [3:0] req_dpad_buttons,
   input  logic [5:0] req_face_buttons,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_stick_x,
   output logic [7:0] rsp_stick_y,
   output logic [7:0] rsp_c_stick_x,
   output logic [7:0] rsp_c_stick_y,
   output logic [3:0] rsp_dpad_out,
   output logic [7:0] rsp_left_trigger,
   output logic [7:0] rsp_right_trigger,
   output logic [7:0] rsp_button_bits,

   input  logic       csr_write_en,
   input  logic [1:0] csr_index,
   input  logic [0:0] csr_wdata
);

   // Configuration registers.
   logic socd_mode_ff, socd_mode_in;
   logic ban_parasol_ff, ban_parasol_in;
   logic ban_side_b_ff, ban_side_b_in;

   // Direction state.
   logic [3:0] last_pressed_ff, last_pressed_in;
   logic [3:0] locked_out_ff, locked_out_in;

   // Pipeline registers.
   logic         req_valid_ff, req_valid_in;
   req_item_type req_item_ff, req_item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic out_ready;
   logic advance;
   logic req_accept;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign advance    = req_valid_ff && out_ready;
   assign req_stall  = req_valid_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;

   // Configuration writes.
   always_comb begin
      socd_mode_in   = socd_mode_ff;
      ban_parasol_in = ban_parasol_ff;
      ban_side_b_in  = ban_side_b_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_SOCD_MODE:   socd_mode_in   = csr_wdata[0];
            REG_BAN_PARASOL: ban_parasol_in = csr_wdata[0];
            REG_BAN_SIDE_B:  ban_side_b_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Input register control.
   always_comb begin
      req_valid_in = req_valid_ff;
      req_item_in  = req_item_ff;
      if (req_accept) begin
         req_valid_in                  = 1'b1;
         req_item_in.direction_buttons = req_direction_buttons;
         req_item_in.modifier_buttons  = req_modifier_buttons;
         req_item_in.shield_buttons    = req_shield_buttons;
         req_item_in.c_buttons         = req_c_buttons;
         req_item_in.dpad_buttons      = req_dpad_buttons;
         req_item_in.face_buttons      = req_face_buttons;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   // Opposite-direction resolution and report lookup.
   logic [3:0] raw, dir, lock_new;
   logic [3:0] sh, cb;
   logic [5:0] fb;
   logic mx, my, bb, cl, cr, cu, cd, rawlr, lr, ud;
   logic right, up, horiz, vert, cv, ch;
   logic signed [7:0] kx, ky, kcx, kcy;
   logic [7:0] sx, sy, cx, cy;
   rsp_item_type report;

   always_comb begin
      raw   = req_item_ff.direction_buttons;
      sh    = req_item_ff.shield_buttons;
      cb    = req_item_ff.c_buttons;
      fb    = req_item_ff.face_buttons;
      mx    = req_item_ff.modifier_buttons[0];
      my    = req_item_ff.modifier_buttons[1];
      bb    = fb[1];
      cl    = cb[0];
      cr    = cb[1];
      cu    = cb[2];
      cd    = cb[3];
      rawlr = raw[1:0] == 2'b11;
      lr    = raw[1:0] == 2'b11;
      ud    = raw[3:2] == 2'b11;

      // A direction is locked out when its opposite arrives while it was
      // already held; the lock falls away once the direction is released.
      lock_new = locked_out_ff | {last_pressed_ff[3] & ud & !last_pressed_ff[2],
                                  last_pressed_ff[2] & ud & !last_pressed_ff[3],
                                  last_pressed_ff[1] & lr & !last_pressed_ff[0],
                                  last_pressed_ff[0] & lr & !last_pressed_ff[1]};
      lock_new = lock_new & raw;

      last_pressed_in = last_pressed_ff;
      locked_out_in   = locked_out_ff;
      if (socd_mode_ff == SOCD_CANCEL) begin
         dir = raw;
         if (lr) dir[1:0] = 2'b00;
         if (ud) dir[3:2] = 2'b00;
      end else begin
         dir = raw & ~lock_new;
         if (advance) begin
            last_pressed_in = raw;
            locked_out_in   = lock_new;
         end
      end

      right = dir[1];
      up    = dir[2];
      horiz = dir[0] | dir[1];
      vert  = dir[2] | dir[3];

      // Main stick magnitudes, in steps of 1/80.
      priority if (vert && horiz) begin
         priority if (sh != 4'd0) begin
            priority if (mx == my) begin
               kx = 8'sd56; ky = up ? 8'sd56 : 8'sd55;
            end else if (mx) begin
               kx = 8'sd51; ky = 8'sd30;
            end else if (ban_parasol_ff && up) begin
               kx = 8'sd38; ky = 8'sd70;
            end else begin
               kx = 8'sd40; ky = 8'sd68;
            end
         end else if (bb && mx != my) begin
            if (mx) begin
               priority if (cd) begin kx = 8'sd73; ky = 8'sd36; end
               else if (cl)     begin kx = 8'sd68; ky = 8'sd42; end
               else if (cu)     begin kx = 8'sd59; ky = 8'sd43; end
               else if (cr)     begin kx = 8'sd51; ky = 8'sd43; end
               else             begin kx = 8'sd73; ky = 8'sd31; end
            end else begin
               priority if (cd) begin kx = 8'sd36; ky = 8'sd70; end
               else if (cl)     begin kx = 8'sd42; ky = 8'sd68; end
               else if (cu)     begin kx = 8'sd47; ky = 8'sd64; end
               else if (cr)     begin kx = 8'sd47; ky = 8'sd57; end
               else             begin kx = 8'sd31; ky = 8'sd73; end
            end
         end else if (mx != my) begin
            if (mx) begin
               priority if (cd) begin kx = 8'sd56; ky = 8'sd29; end
               else if (cl)     begin kx = 8'sd63; ky = 8'sd39; end
               else if (cu)     begin kx = 8'sd56; ky = 8'sd41; end
               else if (cr)     begin kx = 8'sd49; ky = 8'sd42; end
               else             begin kx = 8'sd59; ky = 8'sd25; end
            end else begin
               priority if (cd) begin kx = 8'sd29; ky = 8'sd56; end
               else if (cl)     begin kx = 8'sd39; ky = 8'sd63; end
               else if (cu)     begin kx = 8'sd41; ky = 8'sd56; end
               else if (cr)     begin kx = 8'sd51; ky = 8'sd61; end
               else             begin kx = 8'sd25; ky = 8'sd59; end
            end
         end else begin
            kx = 8'sd56; ky = 8'sd56;
         end
      end else if (horiz) begin
         ky = 8'sd0;
         priority if (mx == my) kx = 8'sd80;
         else if (mx) kx = rawlr ? 8'sd80 : 8'sd53;
         else kx = ((ban_side_b_ff && bb) || rawlr) ? 8'sd80 : 8'sd27;
      end else if (vert) begin
         kx = 8'sd0;
         priority if (mx == my) ky = 8'sd80;
         else if (mx) ky = 8'sd43;
         else ky = 8'sd59;
      end else begin
         kx = 8'sd0; ky = 8'sd0;
      end

      sx = coord(kx);
      sy = coord(ky);
      if (horiz && !right) sx = mirror(sx);
      if (vert && !up) sy = mirror(sy);

      // C-stick.
      cv = cu != cd;
      ch = cl != cr;
      priority if (mx && my) begin
         kcx = 8'sd0; kcy = 8'sd0;
      end else if (cv && ch) begin
         kcx = 8'sd42; kcy = 8'sd68;
      end else if (ch) begin
         if (mx) begin
            kcx = 8'sd67; kcy = up ? 8'sd25 : -8'sd25;
         end else begin
            kcx = 8'sd80; kcy = 8'sd0;
         end
      end else if (cv) begin
         kcx = 8'sd0; kcy = 8'sd80;
      end else begin
         kcx = 8'sd0; kcy = 8'sd0;
      end
      cx = coord(kcx);
      cy = coord(kcy);
      if (ch && cl) cx = mirror(cx);
      if (cv && cd) cy = mirror(cy);

      report.stick_x   = sx;
      report.stick_y   = sy;
      report.c_stick_x = cx;
      report.c_stick_y = cy;
      report.dpad_out = (mx && my) ? (req_item_ff.dpad_buttons | cb)
                                   : req_item_ff.dpad_buttons;
      priority if (sh[0]) report.left_trigger = TRIG_FULL;
      else if (sh[3])     report.left_trigger = TRIG_MID;
      else if (sh[2])     report.left_trigger = TRIG_LIGHT;
      else                report.left_trigger = TRIG_OFF;
      report.right_trigger = sh[1] ? TRIG_FULL : TRIG_OFF;
      report.button_bits   = {fb[5], sh[1:0], fb[4:0]};
   end

   // Result register control.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = report;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         socd_mode_ff    <= SOCD_PRIORITY;
         ban_parasol_ff  <= 1'b0;
         ban_side_b_ff   <= 1'b0;
         last_pressed_ff <= 4'd0;
         locked_out_ff   <= 4'd0;
         req_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         socd_mode_ff    <= socd_mode_in;
         ban_parasol_ff  <= ban_parasol_in;
         ban_side_b_ff   <= ban_side_b_in;
         last_pressed_ff <= last_pressed_in;
         locked_out_ff   <= locked_out_in;
         req_valid_ff    <= req_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_item_ff <= req_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_stick_x       = rsp_item_ff.stick_x;
   assign rsp_stick_y       = rsp_item_ff.stick_y;
   assign rsp_c_stick_x     = rsp_item_ff.c_stick_x;
   assign rsp_c_stick_y     = rsp_item_ff.c_stick_y;
   assign rsp_dpad_out      = rsp_item_ff.dpad_out;
   assign rsp_left_trigger  = rsp_item_ff.left_trigger;
   assign rsp_right_trigger = rsp_item_ff.right_trigger;
   assign rsp_button_bits   = rsp_item_ff.button_bits;

   // A direction can only be locked while it is held.
   a_lock_held: assert property (@(posedge clock) disable iff (reset)
      (locked_out_ff & ~last_pressed_ff) == 4'd0)
      else $error("locked direction is not held");

   // Only one side of each axis is ever locked out.
   a_lock_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(locked_out_ff[0] && locked_out_ff[1]) && !(locked_out_ff[2] && locked_out_ff[3]))
      else $error("both directions of an axis are locked out");

   // Neutral mode leaves the direction state untouched.
   a_neutral_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (advance && socd_mode_ff == SOCD_CANCEL) |=>
         ($stable(last_pressed_ff) && $stable(locked_out_ff)))
      else $error("direction state changed in neutral mode");

   // A stalled input side always has a snapshot waiting.
   a_stall_has_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (req_valid_ff && rsp_valid_ff))
      else $error("input stalled without a pending snapshot");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the button box stick mapper, with a built-in mapping predictor.
module testbench
   import bbsm_pkg::*;
();

   localparam logic [1:0] REG_INDEX_UNUSED = 2'd3;
   localparam int DIRECTED_COUNT = 25;
   localparam int PHASE_COUNT = 6;
   localparam int PHASE_ITEMS = 130;

   typedef struct {
      req_item_type snap;
      bit           typed;
      rsp_item_type report;
   } directed_row_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [3:0] req_direction_buttons;
   logic [1:0] req_modifier_buttons;
   logic [3:0] req_shield_buttons;
   logic [3:0] req_c_buttons;
   logic [3:0] req_dpad_buttons;
   logic [5:0] req_face_buttons;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_stick_x;
   logic [7:0] rsp_stick_y;
   logic [7:0] rsp_c_stick_x;
   logic [7:0] rsp_c_stick_y;
   logic [3:0] rsp_dpad_out;
   logic [7:0] rsp_left_trigger;
   logic [7:0] rsp_right_trigger;
   logic [7:0] rsp_button_bits;
   logic       csr_write_en;
   logic [1:0] csr_index;
   logic [0:0] csr_wdata;

   // Shadow copy of the registers and of the opposite-direction state.
   logic       socd_mode_q;
   logic       ban_parasol_q;
   logic       ban_side_b_q;
   logic [3:0] last_dirs;
   logic [3:0] locked_dirs;

   rsp_item_type pending_reports [$];
   int           mismatch_count = 0;
   int           tx_gap_max = 8;
   int           rx_gap_max = 8;
   int           hold_left = 0;
   int           long_hold = 0;
   logic [3:0]   last_sent_dirs = 4'b0000;

   // Settings per phase, packed as {ban_slight_side_b, ban_parasol_dashing, socd_mode}.
   localparam logic [2:0] PHASE_SETTINGS [PHASE_COUNT] =
      '{3'b110, 3'b011, 3'b100, 3'b111, 3'b000, 3'b001};

   // Directions are {down, up, right, left}; faces are {start, Z, Y, X, B, A}.
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{'{4'b0000, 2'b00, 4'b0000, 4'b0000, 4'b0000, 6'b000000}, 1'b1,
        '{8'd128, 8'd128, 8'd128, 8'd128, 4'd0, 8'd0, 8'd0, 8'd0}},
      '{'{4'b0000, 2'b00, 4'b1111, 4'b0000, 4'b0000, 6'b111111}, 1'b1,
        '{8'd128, 8'd128, 8'd128, 8'd128, 4'd0, 8'd140, 8'd140, 8'd255}},
      '{'{4'b0000, 2'b11, 4'b0000, 4'b1111, 4'b1111, 6'b000000}, 1'b1,
        '{8'd128, 8'd128, 8'd128, 8'd128, 4'd15, 8'd0, 8'd0, 8'd0}},
      '{'{4'b0000, 2'b00, 4'b1000, 4'b0000, 4'b0000, 6'b000000}, 1'b1,
        '{8'd128, 8'd128, 8'd128, 8'd128, 4'd0, 8'd94, 8'd0, 8'd0}},
      '{'{4'b0000, 2'b00, 4'b0100, 4'b0000, 4'b0000, 6'b000000}, 1'b1,
        '{8'd128, 8'd128, 8'd128, 8'd128, 4'd0, 8'd49, 8'd0, 8'd0}},
      '{'{4'b0010, 2'b00, 4'b0000, 4'b0000, 4'b0000, 6'b000000}, 1'b1,
        '{8'd208, 8'd128, 8'd128, 8'd128, 4'd0, 8'd0, 8'd0, 8'd0}},
      '{'{4'b0001, 2'b00, 4'b0000, 4'b0000, 4'b0000, 6'b000000}, 1'b1,
        '{8'd48, 8'd128, 8'd128, 8'd128, 4'd0, 8'd0, 8'd0, 8'd0}},
      // Left was held first, so adding right locks left out.
      '{'{4'b0011, 2'b00, 4'b0000, 4'b0000, 4'b0000, 6'b000000}, 1'b0, '0},
      '{'{4'b0011, 2'b00, 4'b0000, 4'b0000, 4'b0000, 6'b000000}, 1'b0, '0},
      '{'{4'b0010, 2'b00, 4'b0000, 4'b0000, 4'b0000, 6'b000000}, 1'b0, '0},
      '{'{4'b1100, 2'b00, 4'b0000, 4'b0000, 4'b0000, 6'b000000}, 1'b0, '0},
      '{'{4'b0100, 2'b00, 4'b0000, 4'b0000, 4'b0000, 6'b000000}, 1'b0, '0},
      '{'{4'b1100, 2'b00, 4'b0000, 4'b0000, 4'b0000, 6'b000000}, 1'b0, '0},
      '{'{4'b0110, 2'b00, 4'b0001, 4'b0000, 4'b0000, 6'b000000}, 1'b0, '0},
      '{'{4'b1001, 2'b01, 4'b0010, 4'b0000, 4'b0000, 6'b000000}, 1'b0, '0},
      '{'{4'b0110, 2'b10, 4'b0100, 4'b0000, 4'b0000, 6'b000000}, 1'b0, '0},
      '{'{4'b0101, 2'b01, 4'b0000, 4'b1000, 4'b0000, 6'b000010}, 1'b0, '0},
      '{'{4'b1010, 2'b10, 4'b0000, 4'b0001, 4'b0000, 6'b000010}, 1'b0, '0},
      '{'{4'b0110, 2'b01, 4'b0000, 4'b0100, 4'b0000, 6'b000000}, 1'b0, '0},
      '{'{4'b1001, 2'b10, 4'b0000, 4'b0010, 4'b0000, 6'b000000}, 1'b0, '0},
      // Raw left and right together with one modifier give full horizontal.
      '{'{4'b0011, 2'b01, 4'b0000, 4'b0000, 4'b0000, 6'b000000}, 1'b0, '0},
      '{'{4'b0001, 2'b10, 4'b0000, 4'b0000, 4'b0000, 6'b000010}, 1'b0, '0},
      '{'{4'b0100, 2'b01, 4'b0000, 4'b0101, 4'b0000, 6'b000000}, 1'b0, '0},
      '{'{4'b1000, 2'b01, 4'b0000, 4'b0010, 4'b0000, 6'b000000}, 1'b0, '0},
      '{'{4'b0000, 2'b10, 4'b0000, 4'b1000, 4'b0000, 6'b000000}, 1'b0, '0}
   };

   button_box_stick_mapper_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_direction_buttons (req_direction_buttons),
      .req_modifier_buttons  (req_modifier_buttons),
      .req_shield_buttons    (req_shield_buttons),
      .req_c_buttons     (req_c_buttons),
      .req_dpad_buttons  (req_dpad_buttons),
      .req_face_buttons  (req_face_buttons),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_stick_x       (rsp_stick_x),
      .rsp_stick_y       (rsp_stick_y),
      .rsp_c_stick_x     (rsp_c_stick_x),
      .rsp_c_stick_y     (rsp_c_stick_y),
      .rsp_dpad_out      (rsp_dpad_out),
      .rsp_left_trigger  (rsp_left_trigger),
      .rsp_right_trigger (rsp_right_trigger),
      .rsp_button_bits   (rsp_button_bits),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] to_coord(input int k);
      return 8'(128 + k);
   endfunction

   function automatic logic [7:0] flip_axis(input logic [7:0] c);
      return 8'(256 - int'(c));
   endfunction

   // Works out the report for one snapshot and, in priority mode, advances the direction state.
   function automatic rsp_item_type map_snapshot(input req_item_type s);
      rsp_item_type r;
      logic [3:0]   d;
      logic [3:0]   lo;
      logic         mx, my, cl, cr, cu, cd, bb, raw_lr;
      logic         right, up, horiz, vert, cv, ch;
      int           kx, ky;
      d = s.direction_buttons;
      mx = s.modifier_buttons[0];
      my = s.modifier_buttons[1];
      cl = s.c_buttons[0];
      cr = s.c_buttons[1];
      cu = s.c_buttons[2];
      cd = s.c_buttons[3];
      bb = s.face_buttons[1];
      raw_lr = (d[1:0] == 2'b11);
      if (socd_mode_q == SOCD_CANCEL) begin
         if (d[1:0] == 2'b11) d[1:0] = 2'b00;
         if (d[3:2] == 2'b11) d[3:2] = 2'b00;
      end else begin
         // The direction held before its opposite arrived is locked out.
         lo = locked_dirs;
         if (last_dirs[0] && d[1:0] == 2'b11 && !last_dirs[1]) lo[0] = 1'b1;
         if (last_dirs[1] && d[1:0] == 2'b11 && !last_dirs[0]) lo[1] = 1'b1;
         if (last_dirs[2] && d[3:2] == 2'b11 && !last_dirs[3]) lo[2] = 1'b1;
         if (last_dirs[3] && d[3:2] == 2'b11 && !last_dirs[2]) lo[3] = 1'b1;
         lo &= d;
         last_dirs = d;
         locked_dirs = lo;
         d &= ~lo;
      end
      right = d[1];
      up = d[2];
      horiz = (d[1:0] != 2'b00);
      vert = (d[3:2] != 2'b00);

      if (vert && horiz) begin
         if (s.shield_buttons != 4'b0000) begin
            if (mx == my) begin
               kx = 56;
               ky = up ? 56 : 55;
            end else if (mx) begin
               kx = 51; ky = 30;
            end else if (ban_parasol_q && up) begin
               kx = 38; ky = 70;
            end else begin
               kx = 40; ky = 68;
            end
         end else if (bb && mx != my) begin
            if (mx) begin
               if (cd) begin kx = 73; ky = 36; end
               else if (cl) begin kx = 68; ky = 42; end
               else if (cu) begin kx = 59; ky = 43; end
               else if (cr) begin kx = 51; ky = 43; end
               else begin kx = 73; ky = 31; end
            end else begin
               if (cd) begin kx = 36; ky = 70; end
               else if (cl) begin kx = 42; ky = 68; end
               else if (cu) begin kx = 47; ky = 64; end
               else if (cr) begin kx = 47; ky = 57; end
               else begin kx = 31; ky = 73; end
            end
         end else if (mx != my) begin
            if (mx) begin
               if (cd) begin kx = 56; ky = 29; end
               else if (cl) begin kx = 63; ky = 39; end
               else if (cu) begin kx = 56; ky = 41; end
               else if (cr) begin kx = 49; ky = 42; end
               else begin kx = 59; ky = 25; end
            end else begin
               if (cd) begin kx = 29; ky = 56; end
               else if (cl) begin kx = 39; ky = 63; end
               else if (cu) begin kx = 41; ky = 56; end
               else if (cr) begin kx = 51; ky = 61; end
               else begin kx = 25; ky = 59; end
            end
         end else begin
            kx = 56; ky = 56;
         end
      end else if (horiz) begin
         ky = 0;
         if (mx == my) kx = 80;
         else if (mx) kx = raw_lr ? 80 : 53;
         else kx = ((ban_side_b_q && bb) || raw_lr) ? 80 : 27;
      end else if (vert) begin
         kx = 0;
         if (mx == my) ky = 80;
         else if (mx) ky = 43;
         else ky = 59;
      end else begin
         kx = 0; ky = 0;
      end

      r.stick_x = to_coord(kx);
      r.stick_y = to_coord(ky);
      if (horiz && !right) r.stick_x = flip_axis(r.stick_x);
      if (vert && !up) r.stick_y = flip_axis(r.stick_y);

      cv = (cu != cd);
      ch = (cl != cr);
      if (mx && my) begin
         r.c_stick_x = to_coord(0); r.c_stick_y = to_coord(0);
      end else if (cv && ch) begin
         r.c_stick_x = to_coord(42); r.c_stick_y = to_coord(68);
      end else if (ch) begin
         if (mx) begin
            r.c_stick_x = to_coord(67);
            r.c_stick_y = to_coord(up ? 25 : -25);
         end else begin
            r.c_stick_x = to_coord(80); r.c_stick_y = to_coord(0);
         end
      end else if (cv) begin
         r.c_stick_x = to_coord(0); r.c_stick_y = to_coord(80);
      end else begin
         r.c_stick_x = to_coord(0); r.c_stick_y = to_coord(0);
      end
      if (ch && cl) r.c_stick_x = flip_axis(r.c_stick_x);
      if (cv && cd) r.c_stick_y = flip_axis(r.c_stick_y);

      r.dpad_out = (mx && my) ? (s.dpad_buttons | s.c_buttons) : s.dpad_buttons;
      r.left_trigger = s.shield_buttons[0] ? TRIG_FULL :
                       s.shield_buttons[3] ? TRIG_MID :
                       s.shield_buttons[2] ? TRIG_LIGHT : TRIG_OFF;
      r.right_trigger = s.shield_buttons[1] ? TRIG_FULL : TRIG_OFF;
      r.button_bits = {s.face_buttons[5], s.shield_buttons[1:0], s.face_buttons[4:0]};
      return r;
   endfunction

   // Mostly one direction pressed or released per poll, so that lockouts build up.
   function automatic req_item_type random_snapshot();
      req_item_type s;
      if ($urandom_range(0, 3) != 0)
         s.direction_buttons = last_sent_dirs ^ (4'b0001 << $urandom_range(0, 3));
      else
         s.direction_buttons = 4'($urandom);
      s.modifier_buttons = 2'($urandom);
      s.shield_buttons = ($urandom_range(0, 1) != 0) ? 4'($urandom) : 4'b0000;
      s.c_buttons = ($urandom_range(0, 1) != 0) ? 4'($urandom) : 4'b0000;
      s.dpad_buttons = 4'($urandom);
      s.face_buttons = 6'($urandom);
      last_sent_dirs = s.direction_buttons;
      return s;
   endfunction

   function automatic void check_field(input string field_name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field_name, want, got);
         mismatch_count++;
      end
   endfunction

   // Entered and left at a falling edge.
   task automatic send_snapshot(input req_item_type snap, input bit typed,
                                input rsp_item_type typed_report);
      int           gap;
      rsp_item_type predicted;
      gap = $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_direction_buttons = snap.direction_buttons;
      req_modifier_buttons = snap.modifier_buttons;
      req_shield_buttons = snap.shield_buttons;
      req_c_buttons = snap.c_buttons;
      req_dpad_buttons = snap.dpad_buttons;
      req_face_buttons = snap.face_buttons;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = map_snapshot(snap);
      pending_reports.push_back(typed ? typed_report : predicted);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic value);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      case (idx)
         REG_SOCD_MODE: socd_mode_q = value;
         REG_BAN_PARASOL: ban_parasol_q = value;
         REG_BAN_SIDE_B: ban_side_b_q = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // Receiver: stalls for the drawn count after each transfer, or for a long hold-off.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold > 0) begin
            rsp_stall = 1'b1;
            long_hold--;
         end else if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         hold_left = $urandom_range(0, rx_gap_max);
         if (pending_reports.size() == 0) begin
            $display("%0t: report with none expected, stick %0d/%0d", $time,
                     rsp_stick_x, rsp_stick_y);
            mismatch_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("stick_x", want.stick_x, rsp_stick_x);
            check_field("stick_y", want.stick_y, rsp_stick_y);
            check_field("c_stick_x", want.c_stick_x, rsp_c_stick_x);
            check_field("c_stick_y", want.c_stick_y, rsp_c_stick_y);
            check_field("dpad_out", want.dpad_out, rsp_dpad_out);
            check_field("left_trigger", want.left_trigger, rsp_left_trigger);
            check_field("right_trigger", want.right_trigger, rsp_right_trigger);
            check_field("button_bits", want.button_bits, rsp_button_bits);
         end
      end
   end

   initial begin
      #2000000;
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_direction_buttons = 4'b0000;
      req_modifier_buttons = 2'b00;
      req_shield_buttons = 4'b0000;
      req_c_buttons = 4'b0000;
      req_dpad_buttons = 4'b0000;
      req_face_buttons = 6'b000000;
      csr_write_en = 1'b0;
      csr_index = REG_SOCD_MODE;
      csr_wdata = 1'b0;
      socd_mode_q = SOCD_PRIORITY;
      ban_parasol_q = 1'b0;
      ban_side_b_q = 1'b0;
      last_dirs = 4'b0000;
      locked_dirs = 4'b0000;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_snapshot(directed_rows[i].snap, directed_rows[i].typed,
                       directed_rows[i].report);
         last_sent_dirs = directed_rows[i].snap.direction_buttons;
      end
      wait_drained();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_register(REG_SOCD_MODE, PHASE_SETTINGS[p][0]);
         write_register(REG_BAN_PARASOL, PHASE_SETTINGS[p][1]);
         write_register(REG_BAN_SIDE_B, PHASE_SETTINGS[p][2]);
         // A write past the last register must leave every setting alone.
         if (p == PHASE_COUNT - 1) write_register(REG_INDEX_UNUSED, 1'b1);
         tx_gap_max = (p == 3) ? 0 : 8;
         rx_gap_max = (p == 3) ? 0 : 8;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // The sender keeps offering while the receiver holds off, so the block fills up.
            if (p == 1 && n == 40) long_hold = 300;
            if (p == 1 && n == 90) wait_drained();
            send_snapshot(random_snapshot(), 1'b0, '0);
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
